// ----- rtl/core/arbm_pkg.sv -----
`default_nettype none

package arbm_pkg;

    localparam int MAX_RULES = 64;
    localparam int KEY_WIDTH = 16;
    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam int TYPES_W = 7;
    localparam int STYPE_W = 3;
    localparam int IN_FIELDS_W = 2 * KEY_WIDTH + 2 + TYPES_W + 1 + STYPE_W;
    localparam int IN_DATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_CHECK = 2'd1,
        MODE_EMPTY = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        VERDICT_ALLOW   = 2'd0,
        VERDICT_NOMATCH = 2'd1,
        VERDICT_BLOCK   = 2'd2,
        VERDICT_NONE    = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        REASON_NONE      = 2'd0,
        REASON_NO_TABLES = 2'd1,
        REASON_NOMATCH   = 2'd2,
        REASON_BLOCKED   = 2'd3
    } reason_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     idx;
        logic [KEY_WIDTH-1:0] user_id;
        logic                 user_wild;
        logic [KEY_WIDTH-1:0] table_id;
        logic                 table_wild;
        logic [TYPES_W-1:0]   types;
        logic                 allow;
    } rule_wr_t;

    typedef struct packed {
        logic                 valid;
        logic [KEY_WIDTH-1:0] user_key;
        logic [KEY_WIDTH-1:0] table_key;
        logic [STYPE_W-1:0]   stype;
        logic                 found;
        logic [1:0]           score;
        logic                 allow;
    } token_t;

    function automatic logic type_ok(input logic [TYPES_W-1:0] types,
                                     input logic [STYPE_W-1:0] stype);
        logic [TYPES_W:0] ext;
        ext = {1'b0, types};
        return (types == '0) || ext[stype];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/arbm_cell.sv -----
`default_nettype none

module arbm_cell (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [arbm_pkg::IDX_W-1:0] cell_idx,
    input  wire logic [arbm_pkg::CNT_W-1:0] rules_stored,
    input  wire arbm_pkg::rule_wr_t      wr,
    input  wire arbm_pkg::token_t        tok_in,
    output arbm_pkg::token_t             tok_out
);
    import arbm_pkg::*;

    logic [KEY_WIDTH-1:0] user_id_reg;
    logic                 user_wild_reg;
    logic [KEY_WIDTH-1:0] table_id_reg;
    logic                 table_wild_reg;
    logic [TYPES_W-1:0]   types_reg;
    logic                 allow_reg;

    logic   valid_reg;
    token_t tok_reg;
    token_t tok_next;

    logic       occupied;
    logic       hit;
    logic [1:0] score;
    logic       take;

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.idx == cell_idx)
        begin
            user_id_reg    <= wr.user_id;
            user_wild_reg  <= wr.user_wild;
            table_id_reg   <= wr.table_id;
            table_wild_reg <= wr.table_wild;
            types_reg      <= wr.types;
            allow_reg      <= wr.allow;
        end
    end

    always_comb
    begin
        occupied = {{(CNT_W - IDX_W){1'b0}}, cell_idx} < rules_stored;
        hit = occupied
            && (user_wild_reg || user_id_reg == tok_in.user_key)
            && (table_wild_reg || table_id_reg == tok_in.table_key)
            && type_ok(types_reg, tok_in.stype);
        score = {!user_wild_reg, !table_wild_reg};
        take = hit && (!tok_in.found || score > tok_in.score
                       || (score == tok_in.score && !allow_reg));
        tok_next = tok_in;
        if (take)
        begin
            tok_next.found = 1'b1;
            tok_next.score = score;
            tok_next.allow = allow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = valid_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/core/arbm_chain.sv -----
`default_nettype none

module arbm_chain (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [arbm_pkg::CNT_W-1:0] rules_stored,
    input  wire arbm_pkg::rule_wr_t         wr,
    input  wire arbm_pkg::token_t           tok_in,
    output arbm_pkg::token_t                tok_out
);
    import arbm_pkg::*;

    token_t link [0:MAX_RULES];

    assign link[0] = tok_in;

    for (genvar i = 0; i < MAX_RULES; i++)
    begin : g_cell
        arbm_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cell_idx     (IDX_W'(i)),
            .rules_stored (rules_stored),
            .wr           (wr),
            .tok_in       (link[i]),
            .tok_out      (link[i+1])
        );
    end

    assign tok_out = link[MAX_RULES];

endmodule

`default_nettype wire

// ----- rtl/core/access_rule_best_match.sv -----
// Access-rule classifier with best-match selection.
// Input stream s_axis: tuser carries the item kind (add rule, check one table,
// query with no tables, no-op), tlast marks the final table of a query, tdata the
// rule or query fields. Output stream m_axis: one transfer per input item,
// tlast set when the final query verdict is given.
// Rules live in a row of MAX_RULES cells, one rule each. A check injects a
// token at the head of the row; it advances one cell per cycle and each cell
// folds its rule into the best match so far. The time a check takes from
// transfer to result is set by the length of the cell row; add and no-table
// items do not pass through the row. One item is in work at a time; the next
// transfer is taken only once the result of the item before is in the output register.
// The result waits in an output register; when the receiver stalls, the block
// still takes the next item and holds its result until the register frees.
// Reset clears the rule count, the sticky query denial and all handshakes;
// rule contents are not cleared and are never read before being written.
`default_nettype none

module access_rule_best_match (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // user_key, user_any, table_key, table_any, type_mask, effect_allow,
    // statement_type, zero fill
    input  wire logic [arbm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                            s_axis_tlast,
    // mode
    input  wire logic [1:0]                      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // rule_accepted, table_verdict, query_allowed, deny_reason, zero fill
    output logic [arbm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast
);
    import arbm_pkg::*;

    localparam int UA_B = KEY_WIDTH;
    localparam int TK_L = KEY_WIDTH + 1;
    localparam int TA_B = 2 * KEY_WIDTH + 1;
    localparam int TM_L = 2 * KEY_WIDTH + 2;
    localparam int EA_B = TM_L + TYPES_W;
    localparam int ST_L = EA_B + 1;

    state_t   state_reg, state_next;
    mode_t    mode_reg;
    logic     last_reg;
    logic     acc_reg;
    verdict_t verdict_reg;

    logic [CNT_W-1:0] count_reg;
    logic             denied_reg;
    reason_t          first_reason_reg;

    logic     out_valid_reg;
    logic     out_acc_reg;
    verdict_t out_verdict_reg;
    logic     out_done_reg;
    logic     out_allowed_reg;
    reason_t  out_reason_reg;

    logic     in_xfer;
    logic     load_out;
    mode_t    in_mode;
    logic     full;
    rule_wr_t wr;
    token_t   tok_in;
    token_t   tok_out;

    logic     r_acc;
    verdict_t r_verdict;
    logic     r_done;
    logic     r_allowed;
    reason_t  r_reason;
    logic     r_denied;
    reason_t  r_first;
    verdict_t chain_verdict;

    assign in_mode = mode_t'(s_axis_tuser);
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign full    = (count_reg == CNT_W'(MAX_RULES));

    always_comb
    begin
        wr.en         = in_xfer && in_mode == MODE_ADD && !full;
        wr.idx        = count_reg[IDX_W-1:0];
        wr.user_id    = s_axis_tdata[KEY_WIDTH-1:0];
        wr.user_wild  = s_axis_tdata[UA_B];
        wr.table_id   = s_axis_tdata[TK_L +: KEY_WIDTH];
        wr.table_wild = s_axis_tdata[TA_B];
        wr.types      = s_axis_tdata[TM_L +: TYPES_W];
        wr.allow      = s_axis_tdata[EA_B];

        tok_in.valid     = in_xfer && in_mode == MODE_CHECK;
        tok_in.user_key  = s_axis_tdata[KEY_WIDTH-1:0];
        tok_in.table_key = s_axis_tdata[TK_L +: KEY_WIDTH];
        tok_in.stype     = s_axis_tdata[ST_L +: STYPE_W];
        tok_in.found     = 1'b0;
        tok_in.score     = 2'd0;
        tok_in.allow     = 1'b0;
    end

    arbm_chain u_chain (
        .clk          (clk),
        .rst_n        (rst_n),
        .rules_stored (count_reg),
        .wr           (wr),
        .tok_in       (tok_in),
        .tok_out      (tok_out)
    );

    assign chain_verdict = !tok_out.found ? VERDICT_NOMATCH
                         : (tok_out.allow ? VERDICT_ALLOW : VERDICT_BLOCK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = (in_mode == MODE_CHECK) ? ST_RUN : ST_FINISH;
                end
            end
            ST_RUN:
            begin
                if (tok_out.valid)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        r_acc     = 1'b0;
        r_verdict = VERDICT_NONE;
        r_done    = 1'b0;
        r_allowed = 1'b0;
        r_reason  = REASON_NONE;
        r_denied  = denied_reg;
        r_first   = first_reason_reg;
        case (mode_reg)
            MODE_ADD:
            begin
                r_acc = acc_reg;
            end
            MODE_CHECK:
            begin
                r_verdict = verdict_reg;
                if (!denied_reg && verdict_reg != VERDICT_ALLOW)
                begin
                    r_denied = 1'b1;
                    r_first  = (verdict_reg == VERDICT_NOMATCH) ? REASON_NOMATCH
                                                                : REASON_BLOCKED;
                end
                if (last_reg)
                begin
                    r_done    = 1'b1;
                    r_allowed = !r_denied;
                    r_reason  = r_denied ? r_first : REASON_NONE;
                    r_denied  = 1'b0;
                    r_first   = REASON_NONE;
                end
            end
            MODE_EMPTY:
            begin
                r_done   = 1'b1;
                r_reason = REASON_NO_TABLES;
                r_denied = 1'b0;
                r_first  = REASON_NONE;
            end
            default:
            begin
                r_acc = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            denied_reg       <= 1'b0;
            first_reason_reg <= REASON_NONE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (load_out)
            begin
                denied_reg       <= r_denied;
                first_reason_reg <= r_first;
                out_valid_reg    <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg <= in_mode;
            last_reg <= s_axis_tlast;
            acc_reg  <= !full;
        end
        if (state_reg == ST_RUN && tok_out.valid)
        begin
            verdict_reg <= chain_verdict;
        end
        if (load_out)
        begin
            out_acc_reg     <= r_acc;
            out_verdict_reg <= r_verdict;
            out_done_reg    <= r_done;
            out_allowed_reg <= r_allowed;
            out_reason_reg  <= r_reason;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_done_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - 6){1'b0}}, out_reason_reg, out_allowed_reg,
                            out_verdict_reg, out_acc_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RULES))
        else $error("rule count above capacity");

    a_chain_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        tok_out.valid |-> state_reg == ST_RUN)
        else $error("chain result outside run state");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_mode == MODE_ADD && full) |=> $stable(count_reg))
        else $error("rule stored into full table");

    a_reason_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_done_reg) |-> (out_reason_reg == REASON_NONE
                                              && !out_allowed_reg))
        else $error("verdict given without query end");

    a_tready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !s_axis_tready)
        else $error("transfer taken while chain busy");

endmodule

`default_nettype wire

// ----- tb/sv/access_rule_best_match_tb.sv -----
`default_nettype none

module access_rule_best_match_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import arbm_pkg::*;

    localparam int ITEM_TARGET = 1600;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 80;
    localparam int CALM_FROM = 1350;
    localparam logic [KEY_WIDTH-1:0] KEY_ONES = {KEY_WIDTH{1'b1}};

    typedef struct {
        mode_t                mode;
        logic [KEY_WIDTH-1:0] user_key;
        logic                 user_any;
        logic [KEY_WIDTH-1:0] tbl_key;
        logic                 tbl_any;
        logic [TYPES_W-1:0]   type_mask;
        logic                 effect_allow;
        logic [STYPE_W-1:0]   stype;
        logic                 last_table;
    } access_item_t;

    typedef struct {
        logic     accepted;
        verdict_t verdict;
        logic     done;
        logic     allowed;
        reason_t  reason;
    } access_outcome_t;

    class verdict_board;
        logic [KEY_WIDTH-1:0] user_id [MAX_RULES];
        logic                 user_wild [MAX_RULES];
        logic [KEY_WIDTH-1:0] tbl_id [MAX_RULES];
        logic                 tbl_wild [MAX_RULES];
        logic [TYPES_W-1:0]   types [MAX_RULES];
        logic                 allow [MAX_RULES];
        int                   rules_held;
        logic                 denied;
        reason_t              held_reason;
        access_outcome_t      pending [$];
        int                   mismatches;
        int                   rules_added;
        int                   rules_refused;
        int                   tables_checked;
        int                   verdicts_given;

        function new();
            rules_held = 0;
            denied = 1'b0;
            held_reason = REASON_NONE;
            mismatches = 0;
            rules_added = 0;
            rules_refused = 0;
            tables_checked = 0;
            verdicts_given = 0;
        endfunction

        function verdict_t classify_table(logic [KEY_WIDTH-1:0] user,
                                          logic [KEY_WIDTH-1:0] tbl,
                                          logic [STYPE_W-1:0] stype);
            int best;
            logic best_allow;
            int score;
            logic [TYPES_W:0] admits;
            best = -1;
            best_allow = 1'b0;
            for (int i = 0; i < rules_held; i++)
            begin
                score = 0;
                admits = {1'b0, types[i]};
                if (!user_wild[i])
                begin
                    if (user_id[i] != user)
                        continue;
                    score += 2;
                end
                if (!tbl_wild[i])
                begin
                    if (tbl_id[i] != tbl)
                        continue;
                    score += 1;
                end
                if (types[i] != '0 && !admits[stype])
                    continue;
                if (score > best || (score == best && !allow[i]))
                begin
                    best = score;
                    best_allow = allow[i];
                end
            end
            if (best < 0)
                return VERDICT_NOMATCH;
            return best_allow ? VERDICT_ALLOW : VERDICT_BLOCK;
        endfunction

        function void admit_item(access_item_t it);
            access_outcome_t o;
            verdict_t v;
            o.accepted = 1'b0;
            o.verdict = VERDICT_NONE;
            o.done = 1'b0;
            o.allowed = 1'b0;
            o.reason = REASON_NONE;
            case (it.mode)
                MODE_ADD:
                begin
                    if (rules_held < MAX_RULES)
                    begin
                        user_id[rules_held] = it.user_key;
                        user_wild[rules_held] = it.user_any;
                        tbl_id[rules_held] = it.tbl_key;
                        tbl_wild[rules_held] = it.tbl_any;
                        types[rules_held] = it.type_mask;
                        allow[rules_held] = it.effect_allow;
                        rules_held++;
                        o.accepted = 1'b1;
                        rules_added++;
                    end
                    else
                        rules_refused++;
                end
                MODE_CHECK:
                begin
                    v = classify_table(it.user_key, it.tbl_key, it.stype);
                    o.verdict = v;
                    tables_checked++;
                    if (!denied && v != VERDICT_ALLOW)
                    begin
                        denied = 1'b1;
                        held_reason = (v == VERDICT_NOMATCH) ? REASON_NOMATCH
                                                             : REASON_BLOCKED;
                    end
                    if (it.last_table)
                    begin
                        o.done = 1'b1;
                        o.allowed = !denied;
                        o.reason = denied ? held_reason : REASON_NONE;
                        denied = 1'b0;
                        held_reason = REASON_NONE;
                        verdicts_given++;
                    end
                end
                MODE_EMPTY:
                begin
                    o.done = 1'b1;
                    o.reason = REASON_NO_TABLES;
                    denied = 1'b0;
                    held_reason = REASON_NONE;
                    verdicts_given++;
                end
                default: ;
            endcase
            pending.insert(pending.size(), o);
        endfunction

        function void compare_field(string name, logic [7:0] exp, logic [7:0] act);
            if (exp !== act)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
                mismatches++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
            access_outcome_t o;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual data %0h last %0b",
                         $time, data, last);
                mismatches++;
                return;
            end
            o = pending.pop_front();
            compare_field("rule_accepted", 8'(o.accepted), 8'(data[0]));
            compare_field("table_verdict", 8'(o.verdict), 8'(data[2:1]));
            compare_field("query_done", 8'(o.done), 8'(last));
            compare_field("query_allowed", 8'(o.allowed), 8'(data[3]));
            compare_field("deny_reason", 8'(o.reason), 8'(data[5:4]));
            compare_field("zero fill", 8'd0, 8'(data[OUT_DATA_W-1:6]));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tlast;
    logic [1:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    verdict_board board = new();
    logic bursty;
    int   items_sent;
    int   quiet_cycles;
    int   ready_hold;

    access_rule_best_match uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic access_item_t make_item(mode_t mode, logic [KEY_WIDTH-1:0] user,
                                               logic uany, logic [KEY_WIDTH-1:0] tbl,
                                               logic tany, logic [TYPES_W-1:0] mask,
                                               logic eff, logic [STYPE_W-1:0] stype,
                                               logic last);
        access_item_t it;
        it.mode = mode;
        it.user_key = user;
        it.user_any = uany;
        it.tbl_key = tbl;
        it.tbl_any = tany;
        it.type_mask = mask;
        it.effect_allow = eff;
        it.stype = stype;
        it.last_table = last;
        return it;
    endfunction

    function automatic logic [KEY_WIDTH-1:0] pick_user();
        if ($urandom_range(0, 7) == 0)
            return KEY_WIDTH'($urandom);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return KEY_ONES;
            2: return 16'h1234;
            3: return 16'h00A5;
            4: return 16'h5A00;
            default: return 16'h8001;
        endcase
    endfunction

    function automatic logic [KEY_WIDTH-1:0] pick_table();
        if ($urandom_range(0, 7) == 0)
            return KEY_WIDTH'($urandom);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return KEY_ONES;
            2: return 16'h5678;
            3: return 16'h0F0F;
            4: return 16'hF0F0;
            default: return 16'h8001;
        endcase
    endfunction

    task automatic send_item(input access_item_t it);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        d[IN_FIELDS_W-1:0] = {it.stype, it.effect_allow, it.type_mask, it.tbl_any,
                              it.tbl_key, it.user_any, it.user_key};
        if (bursty && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= it.mode;
        s_axis_tlast <= it.last_table;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.admit_item(it);
        items_sent++;
    endtask

    task automatic send_rule();
        logic [TYPES_W-1:0] mask;
        mask = ($urandom_range(0, 2) == 0) ? '0 : TYPES_W'($urandom);
        send_item(make_item(MODE_ADD, pick_user(), $urandom_range(0, 3) == 0, pick_table(),
                            $urandom_range(0, 3) == 0, mask, 1'($urandom_range(0, 1)),
                            STYPE_W'($urandom), 1'($urandom_range(0, 1))));
    endtask

    task automatic send_query();
        int n_tables;
        logic cut_short;
        logic [KEY_WIDTH-1:0] user;
        n_tables = $urandom_range(1, 4);
        cut_short = ($urandom_range(0, 9) == 0);
        user = pick_user();
        for (int t = 0; t < n_tables; t++)
            send_item(make_item(MODE_CHECK, user, 1'($urandom), pick_table(), 1'($urandom),
                                TYPES_W'($urandom), 1'($urandom),
                                STYPE_W'($urandom_range(0, 7)),
                                (t == n_tables - 1) && !cut_short));
    endtask

    // receiver: random stall bursts while bursty, otherwise ready once a running burst ends
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b1;
        else if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (bursty && $urandom_range(0, 7) == 0)
        begin
            ready_hold <= $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout at %0t with %0d results outstanding", $time,
                     board.pending.size());
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int r;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        s_axis_tuser = MODE_NOP;
        m_axis_tready = 1'b1;
        bursty = 1'b0;
        items_sent = 0;
        quiet_cycles = 0;
        ready_hold = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty rule store, no-table query, ignored mode
        send_item(make_item(MODE_CHECK, '0, 1'b0, '0, 1'b0, '0, 1'b0, 3'd0, 1'b1));
        send_item(make_item(MODE_EMPTY, '0, 1'b0, '0, 1'b0, '0, 1'b0, 3'd0, 1'b0));
        send_item(make_item(MODE_NOP, KEY_ONES, 1'b1, KEY_ONES, 1'b1, '1, 1'b1, '1, 1'b1));
        // rules covering every specificity, masks at both extremes and a tie
        send_item(make_item(MODE_ADD, KEY_ONES, 1'b0, KEY_ONES, 1'b0, '0, 1'b0, 3'd0, 1'b0));
        send_item(make_item(MODE_ADD, '0, 1'b1, '0, 1'b0, 7'h7F, 1'b1, 3'd0, 1'b0));
        send_item(make_item(MODE_ADD, KEY_ONES, 1'b0, '0, 1'b1, 7'h01, 1'b1, 3'd0, 1'b0));
        send_item(make_item(MODE_ADD, '0, 1'b1, '0, 1'b1, 7'h40, 1'b0, 3'd0, 1'b0));
        send_item(make_item(MODE_ADD, 16'h1234, 1'b0, 16'h5678, 1'b0, '0, 1'b1, 3'd0, 1'b0));
        send_item(make_item(MODE_ADD, 16'h1234, 1'b0, 16'h5678, 1'b0, '0, 1'b0, 3'd7, 1'b1));
        // block on the first table stays sticky over a later allow
        send_item(make_item(MODE_CHECK, KEY_ONES, 1'b0, KEY_ONES, 1'b0, '0, 1'b0, 3'd0, 1'b0));
        send_item(make_item(MODE_CHECK, KEY_ONES, 1'b0, '0, 1'b0, '0, 1'b0, 3'd0, 1'b1));
        send_item(make_item(MODE_CHECK, KEY_ONES, 1'b0, '0, 1'b0, '0, 1'b0, 3'd6, 1'b1));
        send_item(make_item(MODE_CHECK, 16'h1234, 1'b0, 16'h5678, 1'b0, '0, 1'b0, 3'd3,
                            1'b1));
        send_item(make_item(MODE_CHECK, '0, 1'b0, 16'hABCD, 1'b0, '0, 1'b0, 3'd1, 1'b1));
        send_item(make_item(MODE_CHECK, '0, 1'b0, '0, 1'b0, '0, 1'b0, 3'd7, 1'b1));
        send_item(make_item(MODE_CHECK, KEY_ONES, 1'b0, KEY_ONES, 1'b0, '0, 1'b0, 3'd7, 1'b1));
        // query abandoned by a no-table item
        send_item(make_item(MODE_CHECK, KEY_ONES, 1'b0, '0, 1'b0, '0, 1'b0, 3'd0, 1'b0));
        send_item(make_item(MODE_CHECK, '0, 1'b0, 16'hABCD, 1'b0, '0, 1'b0, 3'd2, 1'b0));
        send_item(make_item(MODE_EMPTY, KEY_ONES, 1'b1, KEY_ONES, 1'b1, '1, 1'b1, '1, 1'b1));
        send_item(make_item(MODE_CHECK, KEY_ONES, 1'b0, '0, 1'b0, '0, 1'b0, 3'd0, 1'b1));
        send_item(make_item(MODE_ADD, '0, 1'b1, '0, 1'b1, '0, 1'b1, 3'd0, 1'b0));
        send_item(make_item(MODE_CHECK, '0, 1'b1, 16'hABCD, 1'b1, '1, 1'b1, 3'd1, 1'b1));

        while (items_sent < ITEM_TARGET)
        begin
            bursty = (items_sent < CALM_FROM) && (((items_sent / 150) % 2) == 0);
            r = $urandom_range(0, 99);
            if (r < 7)
                send_rule();
            else if (r < 10)
                send_item(make_item(MODE_EMPTY, pick_user(), 1'($urandom), pick_table(),
                                    1'($urandom), TYPES_W'($urandom), 1'($urandom),
                                    STYPE_W'($urandom), 1'($urandom)));
            else if (r < 12)
                send_item(make_item(MODE_NOP, pick_user(), 1'($urandom), pick_table(),
                                    1'($urandom), TYPES_W'($urandom), 1'($urandom),
                                    STYPE_W'($urandom), 1'($urandom)));
            else
                send_query();
        end
        bursty = 1'b0;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d transfers: %0d rules stored, %0d refused on a full store,",
                 items_sent, board.rules_added, board.rules_refused);
        $display("%0d tables checked, %0d query verdicts, %0d mismatches",
                 board.tables_checked, board.verdicts_given, board.mismatches);
        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/arbm_pkg.sv
rtl/core/arbm_cell.sv
rtl/core/arbm_chain.sv
rtl/core/access_rule_best_match.sv
tb/sv/access_rule_best_match_tb.sv
